[rtl/tes_pkg.sv]
// Package for the triangle element stiffness block: widths, shared types,
// constants and the saturation helper. No dependencies.
package tes_pkg;

  localparam int NODE_W  = 16;
  localparam int Q_W     = 32;
  localparam int DIFF_W  = Q_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int FRAC_W  = 16;
  localparam int SNUM_W  = MAG_W + FRAC_W;
  localparam int SDEN_W  = MAG_W + 1;
  localparam int LO_W    = DIFF_W;
  localparam int HI_W    = MAG_W - LO_W;
  localparam int PP_W    = 2 * DIFF_W;
  localparam int LNUM_W  = MAG_W + DIFF_W;
  localparam int FRONT_LAT = 5;
  localparam int DIV_LAT   = Q_W + 1;

  // The load divides by 12 * 2^32: a shift by 34 bits, then a division by 3
  // done as a multiplication by the rounded-up reciprocal 2^35 / 3.
  localparam int LOAD_SHIFT = Q_W + 2;
  localparam int LTOP_W     = LNUM_W - LOAD_SHIFT;
  localparam int RECIP_W    = Q_W + 2;
  localparam int LPROD_W    = 2 * RECIP_W;

  localparam logic [LNUM_W-1:0]  LOAD_BIAS = LNUM_W'(6) << Q_W;
  localparam logic [LTOP_W-1:0]  LOAD_LIM  = LTOP_W'(3) << Q_W;
  localparam logic [RECIP_W-1:0] RECIP3    = 34'h2_AAAA_AAAB;

  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef logic [1:0] tes_row_t;
  localparam tes_row_t FIRST_ROW = 2'd0;
  localparam tes_row_t LAST_ROW  = 2'd2;

  typedef struct packed {
    logic [2:0][NODE_W-1:0] node;
    logic [2:0][Q_W-1:0]    x;
    logic [2:0][Q_W-1:0]    y;
    logic [2:0][Q_W-1:0]    f;
  } tes_item_t;

  typedef struct packed {
    logic                   valid;
    tes_row_t               row;
    tes_item_t              item;
  } tes_seq_t;

  typedef struct packed {
    logic [NODE_W-1:0]      row_node;
    logic [2:0][NODE_W-1:0] col_node;
    logic                   last_row;
    logic                   degen;
    logic [2:0]             stiff_neg;
    logic                   load_neg;
  } tes_ctl_t;

  function automatic logic [Q_W-1:0] sat_q(input logic [Q_W-1:0] mag, input logic ovf,
                                           input logic neg);
    logic [Q_W-1:0] r;
    if (neg) begin
      if (ovf || (mag > Q_MIN)) r = Q_MIN;
      else r = -mag;
    end else begin
      if (ovf || (mag > Q_MAX)) r = Q_MAX;
      else r = mag;
    end
    return r;
  endfunction

endpackage

[rtl/tes_if.sv]
// Channel interfaces of the triangle element stiffness block.
// Depends on tes_pkg for the field widths.
interface tes_in_if;
  import tes_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [NODE_W-1:0]        node_a, node_b, node_c;
  logic signed [Q_W-1:0]    xa, ya, xb, yb, xc, yc;
  logic signed [Q_W-1:0]    src_opp_a, src_opp_b, src_opp_c;
  modport source(output valid, node_a, node_b, node_c, xa, ya, xb, yb, xc, yc,
                 src_opp_a, src_opp_b, src_opp_c, input ready);
  modport sink(input valid, node_a, node_b, node_c, xa, ya, xb, yb, xc, yc,
               src_opp_a, src_opp_b, src_opp_c, output ready);
endinterface

interface tes_out_if;
  import tes_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [NODE_W-1:0]        row_node, col_node_0, col_node_1, col_node_2;
  logic signed [Q_W-1:0]    stiff_0, stiff_1, stiff_2, load_add;
  logic                     degenerate;
  logic                     last_row;
  modport source(output valid, row_node, col_node_0, col_node_1, col_node_2, stiff_0,
                 stiff_1, stiff_2, load_add, degenerate, last_row, input ready);
  modport sink(input valid, row_node, col_node_0, col_node_1, col_node_2, stiff_0,
               stiff_1, stiff_2, load_add, degenerate, last_row, output ready);
endinterface

[rtl/tes_div.sv]
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
// Depends on tes_pkg for the quotient width.
module tes_div #(
  parameter int NUM_W = tes_pkg::SNUM_W,
  parameter int DEN_W = tes_pkg::SDEN_W
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [NUM_W-1:0]        num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic [tes_pkg::Q_W-1:0] quo_o,
  output logic                    ovf_o
);
  import tes_pkg::*;

  localparam int TOP_W = NUM_W - Q_W;
  localparam int CMP_W = (TOP_W > DEN_W) ? TOP_W : DEN_W;

  logic [CMP_W-1:0] top_ext, den_ext;
  logic             ovf_d;

  logic [DEN_W-1:0] rem_q [Q_W+1];
  logic [DEN_W-1:0] den_q [Q_W+1];
  logic [Q_W-1:0]   lo_q  [Q_W+1];
  logic [Q_W-1:0]   quo_q [Q_W+1];
  logic             ovf_q [Q_W+1];

  always_comb begin
    top_ext = CMP_W'(num_i[NUM_W-1:Q_W]);
    den_ext = CMP_W'(den_i);
    ovf_d   = top_ext >= den_ext;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= ovf_d ? '0 : DEN_W'(top_ext);
      den_q[0] <= den_i;
      lo_q[0]  <= num_i[Q_W-1:0];
      quo_q[0] <= '0;
      ovf_q[0] <= ovf_d;
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    logic [DEN_W:0] t, diff;
    logic           ge;
    always_comb begin
      t    = {rem_q[k-1], lo_q[k-1][Q_W-1]};
      diff = t - {1'b0, den_q[k-1]};
      ge   = t >= {1'b0, den_q[k-1]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        den_q[k] <= den_q[k-1];
        lo_q[k]  <= {lo_q[k-1][Q_W-2:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][Q_W-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[Q_W];
  assign ovf_o = ovf_q[Q_W];
endmodule

[rtl/tes_seq.sv]
// Row sequencer: holds one element and issues its three rows one after another while en_i is high.
// Depends on tes_pkg and tes_if.
module tes_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  tes_in_if.sink            in_i,
  output tes_pkg::tes_seq_t seq_o
);
  import tes_pkg::*;

  logic      valid_q;
  tes_row_t  row_q;
  tes_item_t item_q, item_d;
  logic      fire;

  assign in_i.ready = en_i && (!valid_q || (row_q == LAST_ROW));
  assign fire       = in_i.valid && in_i.ready;

  always_comb begin
    item_d.node = {in_i.node_c, in_i.node_b, in_i.node_a};
    item_d.x    = {in_i.xc, in_i.xb, in_i.xa};
    item_d.y    = {in_i.yc, in_i.yb, in_i.ya};
    item_d.f    = {in_i.src_opp_c, in_i.src_opp_b, in_i.src_opp_a};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      row_q   <= FIRST_ROW;
    end else if (en_i) begin
      if (fire) begin
        valid_q <= 1'b1;
        row_q   <= FIRST_ROW;
      end else if (valid_q && (row_q != LAST_ROW)) begin
        row_q   <= row_q + 2'd1;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      item_q <= item_d;
    end
  end

  assign seq_o = '{valid: valid_q, row: row_q, item: item_q};
endmodule

[rtl/tes_front.sv]
// Front arithmetic: edge differences, products, determinant and numerators, and
// the divider operands for one row. Five register stages. Depends on tes_pkg.
module tes_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  tes_pkg::tes_seq_t         seq_i,
  output logic                      valid_o,
  output tes_pkg::tes_ctl_t         ctl_o,
  output logic [2:0][tes_pkg::SNUM_W-1:0] snum_o,
  output logic [tes_pkg::SDEN_W-1:0] sden_o,
  output logic [tes_pkg::LNUM_W-1:0] lnum_o
);
  import tes_pkg::*;

  logic [FRONT_LAT-1:0] valid_q;
  tes_ctl_t             ctl_q [FRONT_LAT];
  tes_ctl_t             ctl_d;
  tes_ctl_t             ctl4_d;

  logic signed [DIFF_W-1:0] xs [3], ys [3], fs [3];
  logic signed [DIFF_W-1:0] b_d [3], c_d [3], s_d [3];

  logic signed [DIFF_W-1:0] b1_q [3], c1_q [3];
  logic signed [DIFF_W-1:0] bi1_q, ci1_q, dx1_q, dy2_q, dx2_q, dy1_q, s1_q;

  logic signed [PROD_W-1:0] p0_q, p1_q, bb_q [3], cc_q [3];
  logic signed [DIFF_W-1:0] s2_q;

  logic signed [SUM_W-1:0]  d3_q, n3_q [3];
  logic signed [DIFF_W-1:0] s3_q;

  logic [MAG_W-1:0]  dabs_d, nabs_d [3], dabs4_q, nabs4_q [3];
  logic [DIFF_W-1:0] sabs_d;
  logic [PP_W-1:0]   pplo_q, pphi_q;
  logic              degen4_q, lneg4_q;
  logic [2:0]        sneg4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xs[i] = DIFF_W'(signed'(seq_i.item.x[i]));
      ys[i] = DIFF_W'(signed'(seq_i.item.y[i]));
      fs[i] = DIFF_W'(signed'(seq_i.item.f[i]));
    end
    for (int i = 0; i < 3; i++) begin
      b_d[i] = ys[(i+1)%3] - ys[(i+2)%3];
      c_d[i] = xs[(i+2)%3] - xs[(i+1)%3];
      s_d[i] = fs[(i+1)%3] + fs[(i+2)%3];
    end
    ctl_d           = '0;
    ctl_d.row_node  = seq_i.item.node[seq_i.row];
    ctl_d.col_node  = seq_i.item.node;
    ctl_d.last_row  = seq_i.row == LAST_ROW;
  end

  always_comb begin
    ctl4_d           = ctl_q[FRONT_LAT-2];
    ctl4_d.degen     = degen4_q;
    ctl4_d.stiff_neg = sneg4_q;
    ctl4_d.load_neg  = lneg4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[FRONT_LAT-2:0], seq_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q[0] <= ctl_d;
      for (int k = 1; k < FRONT_LAT - 1; k++) ctl_q[k] <= ctl_q[k-1];
      ctl_q[FRONT_LAT-1] <= ctl4_d;

      for (int i = 0; i < 3; i++) begin
        b1_q[i] <= b_d[i];
        c1_q[i] <= c_d[i];
      end
      bi1_q <= b_d[seq_i.row];
      ci1_q <= c_d[seq_i.row];
      s1_q  <= s_d[seq_i.row];
      dx1_q <= xs[1] - xs[0];
      dy2_q <= ys[2] - ys[0];
      dx2_q <= xs[2] - xs[0];
      dy1_q <= ys[1] - ys[0];

      p0_q <= dx1_q * dy2_q;
      p1_q <= dx2_q * dy1_q;
      for (int j = 0; j < 3; j++) begin
        bb_q[j] <= bi1_q * b1_q[j];
        cc_q[j] <= ci1_q * c1_q[j];
      end
      s2_q <= s1_q;

      d3_q <= SUM_W'(p0_q) - SUM_W'(p1_q);
      for (int j = 0; j < 3; j++) n3_q[j] <= SUM_W'(bb_q[j]) + SUM_W'(cc_q[j]);
      s3_q <= s2_q;

      dabs4_q  <= dabs_d;
      for (int j = 0; j < 3; j++) begin
        nabs4_q[j] <= nabs_d[j];
        sneg4_q[j] <= n3_q[j][SUM_W-1];
      end
      pplo_q   <= dabs_d[LO_W-1:0] * sabs_d;
      pphi_q   <= PP_W'(dabs_d[MAG_W-1:LO_W]) * PP_W'(sabs_d);
      degen4_q <= d3_q == '0;
      lneg4_q  <= s3_q[DIFF_W-1];

      for (int j = 0; j < 3; j++) begin
        snum_o[j] <= (SNUM_W'(nabs4_q[j]) << FRAC_W) + SNUM_W'(dabs4_q);
      end
      sden_o <= {dabs4_q, 1'b0};
      lnum_o <= (LNUM_W'(pphi_q) << LO_W) + LNUM_W'(pplo_q) + LOAD_BIAS;
    end
  end

  always_comb begin
    dabs_d = d3_q[SUM_W-1] ? MAG_W'(-d3_q) : MAG_W'(d3_q);
    for (int j = 0; j < 3; j++) begin
      nabs_d[j] = n3_q[j][SUM_W-1] ? MAG_W'(-n3_q[j]) : MAG_W'(n3_q[j]);
    end
    sabs_d = s3_q[DIFF_W-1] ? DIFF_W'(-s3_q) : DIFF_W'(s3_q);
  end

  assign valid_o = valid_q[FRONT_LAT-1];
  assign ctl_o   = ctl_q[FRONT_LAT-1];
endmodule

[rtl/triangle_element_stiffness.sv]
// Top level of the linear triangle element stiffness block.
// Depends on tes_pkg, tes_if, tes_seq, tes_front and tes_div.
//
// Input channel in_i carries one triangular element per word: three global node
// numbers, three Q16.16 vertices and three Q16.16 edge-midpoint source values.
// Output channel out_o carries three words per element, one stiffness row per
// local vertex in order 0, 1, 2, with last_row set on the third. Each word holds
// the row node, the three column nodes, three saturated Q16.16 stiffness
// entries, the saturated load contribution and the degenerate flag.
// Intake is limited by the one-word-per-cycle output: a new element is accepted
// as the last row of the previous one is issued, and the row sequencer issues one
// row per cycle into the pipeline unless the receiver freezes it. The first row
// passes one sequencer stage, five arithmetic stages, 33 divider stages (overflow
// check plus one quotient bit per stage) and the output register.
// Reset empties every stage. When the receiver holds ready low while a word is
// waiting, the whole pipeline freezes in place and resumes without loss.
module triangle_element_stiffness (
  input  logic       clk_i,
  input  logic       rst_ni,
  tes_in_if.sink     in_i,
  tes_out_if.source  out_o
);
  import tes_pkg::*;

  logic                    adv;
  tes_seq_t                seq;
  logic                    front_valid;
  tes_ctl_t                front_ctl;
  logic [2:0][SNUM_W-1:0]  snum;
  logic [SDEN_W-1:0]       sden;
  logic [LNUM_W-1:0]       lnum;
  logic [2:0][Q_W-1:0]     squo;
  logic [2:0]              sovf;
  logic [Q_W-1:0]          lquo;
  logic                    lovf;

  logic [LTOP_W-1:0]       ltop;
  logic [RECIP_W-1:0]      lm_q;
  logic                    lovf0_q, lovf1_q;
  logic [LPROD_W-1:0]      lprod_q;
  logic [Q_W:0]            lq_q [DIV_LAT-2];

  logic [DIV_LAT-1:0]      dvalid_q;
  tes_ctl_t                dctl_q [DIV_LAT];
  tes_ctl_t                dctl;

  logic                    out_valid_q;
  tes_ctl_t                out_ctl_q;
  logic [2:0][Q_W-1:0]     stiff_q, stiff_d;
  logic [Q_W-1:0]          load_q;

  assign adv = !out_valid_q || out_o.ready;

  tes_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .in_i   (in_i),
    .seq_o  (seq)
  );

  tes_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .seq_i   (seq),
    .valid_o (front_valid),
    .ctl_o   (front_ctl),
    .snum_o  (snum),
    .sden_o  (sden),
    .lnum_o  (lnum)
  );

  for (genvar j = 0; j < 3; j++) begin : g_stiff
    tes_div #(.NUM_W(SNUM_W), .DEN_W(SDEN_W)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (snum[j]),
      .den_i (sden),
      .quo_o (squo[j]),
      .ovf_o (sovf[j])
    );
  end

  // The load quotient is formed in two stages and then delayed to line up
  // with the stiffness dividers.
  assign ltop = lnum[LNUM_W-1:LOAD_SHIFT];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lm_q    <= ltop[RECIP_W-1:0];
      lovf0_q <= ltop >= LOAD_LIM;
      lprod_q <= lm_q * RECIP3;
      lovf1_q <= lovf0_q;
      lq_q[0] <= {lovf1_q, lprod_q[RECIP_W+1 +: Q_W]};
      for (int k = 1; k < DIV_LAT - 2; k++) lq_q[k] <= lq_q[k-1];
    end
  end

  assign lovf = lq_q[DIV_LAT-3][Q_W];
  assign lquo = lq_q[DIV_LAT-3][Q_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      dvalid_q    <= {dvalid_q[DIV_LAT-2:0], front_valid};
      out_valid_q <= dvalid_q[DIV_LAT-1];
    end
  end

  assign dctl = dctl_q[DIV_LAT-1];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      stiff_d[j] = dctl.degen ? '0 : sat_q(squo[j], sovf[j], dctl.stiff_neg[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dctl_q[0] <= front_ctl;
      for (int k = 1; k < DIV_LAT; k++) dctl_q[k] <= dctl_q[k-1];
      out_ctl_q <= dctl;
      stiff_q   <= stiff_d;
      load_q    <= sat_q(lquo, lovf, dctl.load_neg);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.row_node   = out_ctl_q.row_node;
  assign out_o.col_node_0 = out_ctl_q.col_node[0];
  assign out_o.col_node_1 = out_ctl_q.col_node[1];
  assign out_o.col_node_2 = out_ctl_q.col_node[2];
  assign out_o.stiff_0    = stiff_q[0];
  assign out_o.stiff_1    = stiff_q[1];
  assign out_o.stiff_2    = stiff_q[2];
  assign out_o.load_add   = load_q;
  assign out_o.degenerate = out_ctl_q.degen;
  assign out_o.last_row   = out_ctl_q.last_row;
endmodule
